// ===== hw/rtl/tge_pkg.sv =====
// ----------------------------------------------------------------------------
// tge_pkg: shared types and constants for the Tseitin gate encoder
// Literal encodings, gate kinds, hash constants, request/result structs.
// ----------------------------------------------------------------------------
package tge_pkg;

  localparam int unsigned TableDepthDefault = 4096;

  localparam logic [31:0] LitTrue     = 32'h7FFF_FFFF;
  localparam logic [31:0] LitFalse    = 32'h8000_0000;
  localparam logic [31:0] LitMinusOne = 32'hFFFF_FFFF;
  localparam logic [30:0] IdMax       = 31'h7FFF_FFFF;

  localparam logic [2:0] KindNot     = 3'd0;
  localparam logic [2:0] KindAnd     = 3'd1;
  localparam logic [2:0] KindOr      = 3'd2;
  localparam logic [2:0] KindXor     = 3'd3;
  localparam logic [2:0] KindImplies = 3'd4;
  localparam logic [2:0] KindEquals  = 3'd5;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusFull    = 2'd1;
  localparam logic [1:0] StatusNoIds   = 2'd2;

  localparam logic [31:0] HashMulLo   = 32'h9E37_79B1;
  localparam logic [31:0] HashMulHi   = 32'h85EB_CA77;
  localparam logic [31:0] HashMulKind = 32'hC2B2_AE3D;
  localparam logic [31:0] HashMulMix  = 32'h2C1B_3C6D;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] left_operand;
    logic [31:0] right_operand;
  } tge_req_t;

  typedef struct packed {
    logic [31:0] gate_id;
    logic        has_clause;
    logic [31:0] lit_first;
    logic [31:0] lit_second;
    logic [31:0] lit_third;
    logic [31:0] clause_total;
    logic [1:0]  status;
    logic        last;
  } tge_res_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  kind;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [30:0] id;
  } tge_entry_t;

endpackage

// ===== hw/rtl/tge_table.sv =====
// ----------------------------------------------------------------------------
// tge_table: gate hash table storage
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module tge_table #(
  parameter int unsigned TableDepth = tge_pkg::TableDepthDefault,
  localparam int unsigned Aw = $clog2(TableDepth)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [Aw-1:0]       waddr_i,
  input  tge_pkg::tge_entry_t wdata_i,
  input  logic                re_i,
  input  logic [Aw-1:0]       raddr_i,
  output tge_pkg::tge_entry_t rdata_o
);

  tge_pkg::tge_entry_t mem_q [TableDepth];
  tge_pkg::tge_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/tseitin_gate_encoder.sv =====
// ----------------------------------------------------------------------------
// tseitin_gate_encoder: Tseitin gate encoding with structural hashing
// Folds constants, probes a linear-probe gate table, allocates ids, and
// emits one clause per result cycle for a newly allocated gate.
// ----------------------------------------------------------------------------
// Folded or unknown-kind requests give their result in the cycle after
// start. Others: hash states HASHA to HASHD (one shared 32x32 multiplier),
// READ and CMP per table probe, ALLOC, then 1 result per cycle (1 to 4
// results). One request at a time; for the others busy_o is high until
// the last result. Reset: a clearing pass walks all TableDepth entries one
// a cycle with busy_o high. Results are a strobe; the receiver cannot stall.
module tseitin_gate_encoder #(
  parameter int unsigned TableDepth = tge_pkg::TableDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  tge_pkg::tge_req_t req_i,
  output logic              busy_o,
  output logic              res_valid_o,
  output tge_pkg::tge_res_t res_o,
  input  logic              cfg_we_i,
  input  logic [30:0]       cfg_wdata_i
);

  localparam int unsigned Aw = $clog2(TableDepth);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_HASHA = 10'b00_0000_0100,
    S_HASHB = 10'b00_0000_1000,
    S_HASHC = 10'b00_0001_0000,
    S_HASHD = 10'b00_0010_0000,
    S_READ  = 10'b00_0100_0000,
    S_CMP   = 10'b00_1000_0000,
    S_ALLOC = 10'b01_0000_0000,
    S_EMIT  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [2:0]  mode_q, mode_d;
  logic [31:0] a_q, a_d, b_q, b_d, lo_q, lo_d, hi_q, hi_d;
  logic [31:0] mul_q, mul_d, h_q, h_d;
  logic [Aw-1:0] pos_q, pos_d, clr_q, clr_d;
  logic [Aw:0] probes_q, probes_d;
  logic        found_q, found_d;
  logic [30:0] next_id_q, next_id_d, x_q, x_d;
  logic [31:0] clauses_q, clauses_d;
  logic [1:0]  st_q, st_d;
  logic [1:0]  cnt_q, cnt_d;
  tge_pkg::tge_res_t res_q, res_d;
  logic        res_valid_q, res_valid_d;

  // shared multiplier operands
  logic [31:0] mul_a, mul_b;
  logic [31:0] mix, fin;

  // table port
  logic                tab_we, tab_re;
  logic [Aw-1:0]       tab_waddr;
  tge_pkg::tge_entry_t tab_wdata, tab_rdata;

  // fold results
  logic        f_single;
  logic [31:0] f_id, f_a, f_b;
  logic [2:0]  f_mode;

  // clause generation
  logic [31:0] xl, c1, c2, c3;
  logic [1:0]  n_last;

  tge_table #(.TableDepth(TableDepth)) u_table (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_waddr),
    .wdata_i (tab_wdata),
    .re_i    (tab_re),
    .raddr_i (pos_q),
    .rdata_o (tab_rdata)
  );

  // constant folding, with one level of XOR/EQUALS to NOT
  always_comb begin
    logic done, cont;
    f_single = 1'b0;
    f_id     = '0;
    f_mode   = req_i.mode;
    f_a      = req_i.left_operand;
    f_b      = req_i.right_operand;
    done     = 1'b0;
    if (req_i.mode > tge_pkg::KindEquals) begin
      f_single = 1'b1;
      f_id     = req_i.left_operand;
      done     = 1'b1;
    end
    for (int p = 0; p < 2; p++) begin
      cont = 1'b0;
      if (!done) begin
        if (f_mode == tge_pkg::KindNot) begin
          if (f_a == tge_pkg::LitTrue) begin
            f_single = 1'b1; f_id = tge_pkg::LitFalse;
          end else if (f_a == tge_pkg::LitFalse) begin
            f_single = 1'b1; f_id = tge_pkg::LitTrue;
          end
          f_b  = tge_pkg::LitMinusOne;
          done = 1'b1;
        end else begin
          if (f_a == tge_pkg::LitTrue) begin
            if (f_mode == tge_pkg::KindAnd || f_mode == tge_pkg::KindEquals) begin
              f_single = 1'b1; f_id = f_b;
            end else if (f_mode == tge_pkg::KindOr) begin
              f_single = 1'b1; f_id = tge_pkg::LitTrue;
            end else if (f_mode == tge_pkg::KindXor) begin
              f_mode = tge_pkg::KindNot; f_a = f_b; cont = 1'b1;
            end
          end else if (f_a == tge_pkg::LitFalse) begin
            if (f_mode == tge_pkg::KindAnd) begin
              f_single = 1'b1; f_id = tge_pkg::LitFalse;
            end else if (f_mode == tge_pkg::KindEquals) begin
              f_mode = tge_pkg::KindNot; f_a = f_b; cont = 1'b1;
            end else if (f_mode == tge_pkg::KindOr || f_mode == tge_pkg::KindXor) begin
              f_single = 1'b1; f_id = f_b;
            end
          end
          if (!f_single && !cont) begin
            if (f_b == tge_pkg::LitTrue) begin
              if (f_mode == tge_pkg::KindAnd || f_mode == tge_pkg::KindEquals) begin
                f_single = 1'b1; f_id = f_a;
              end else if (f_mode == tge_pkg::KindOr) begin
                f_single = 1'b1; f_id = tge_pkg::LitTrue;
              end else if (f_mode == tge_pkg::KindXor) begin
                f_mode = tge_pkg::KindNot; cont = 1'b1;
              end
            end else if (f_b == tge_pkg::LitFalse) begin
              if (f_mode == tge_pkg::KindAnd) begin
                f_single = 1'b1; f_id = tge_pkg::LitFalse;
              end else if (f_mode == tge_pkg::KindEquals) begin
                f_mode = tge_pkg::KindNot; cont = 1'b1;
              end else if (f_mode == tge_pkg::KindOr || f_mode == tge_pkg::KindXor) begin
                f_single = 1'b1; f_id = f_a;
              end
            end
          end
          if (!cont) begin
            done = 1'b1;
          end
        end
      end
    end
  end

  // hash mixing steps around the shared multiplier
  assign mix = (h_q ^ mul_q) ^ ((h_q ^ mul_q) >> 15);
  assign fin = mul_q ^ (mul_q >> 13);

  always_comb begin
    unique case (state_q)
      S_HASHA: begin mul_a = lo_q; mul_b = tge_pkg::HashMulLo;  end
      S_HASHB: begin mul_a = hi_q; mul_b = tge_pkg::HashMulHi;  end
      S_HASHC: begin mul_a = mix;  mul_b = tge_pkg::HashMulMix; end
      default: begin mul_a = '0;   mul_b = '0;                  end
    endcase
  end

  // clause literals for the current emit step
  assign xl = {1'b0, x_q};

  always_comb begin
    c1 = '0; c2 = '0; c3 = '0;
    unique case (mode_q)
      tge_pkg::KindNot: begin
        n_last = 2'd1;
        unique case (cnt_q)
          2'd0:    begin c1 = -a_q; c2 = -xl; end
          default: begin c1 = a_q;  c2 = xl;  end
        endcase
      end
      tge_pkg::KindAnd: begin
        n_last = 2'd2;
        unique case (cnt_q)
          2'd0:    begin c1 = -a_q; c2 = -b_q; c3 = xl; end
          2'd1:    begin c1 = a_q;  c2 = -xl; end
          default: begin c1 = b_q;  c2 = -xl; end
        endcase
      end
      tge_pkg::KindOr: begin
        n_last = 2'd2;
        unique case (cnt_q)
          2'd0:    begin c1 = a_q;  c2 = b_q; c3 = -xl; end
          2'd1:    begin c1 = -a_q; c2 = xl; end
          default: begin c1 = -b_q; c2 = xl; end
        endcase
      end
      tge_pkg::KindXor: begin
        n_last = 2'd3;
        unique case (cnt_q)
          2'd0:    begin c1 = -a_q; c2 = -b_q; c3 = -xl; end
          2'd1:    begin c1 = -a_q; c2 = b_q;  c3 = xl;  end
          2'd2:    begin c1 = a_q;  c2 = -b_q; c3 = xl;  end
          default: begin c1 = a_q;  c2 = b_q;  c3 = -xl; end
        endcase
      end
      tge_pkg::KindImplies: begin
        n_last = 2'd2;
        unique case (cnt_q)
          2'd0:    begin c1 = -a_q; c2 = b_q; c3 = -xl; end
          2'd1:    begin c1 = a_q;  c2 = xl; end
          default: begin c1 = -b_q; c2 = xl; end
        endcase
      end
      default: begin
        n_last = 2'd3;
        unique case (cnt_q)
          2'd0:    begin c1 = -a_q; c2 = -b_q; c3 = xl;  end
          2'd1:    begin c1 = -a_q; c2 = b_q;  c3 = -xl; end
          2'd2:    begin c1 = a_q;  c2 = -b_q; c3 = -xl; end
          default: begin c1 = a_q;  c2 = b_q;  c3 = xl;  end
        endcase
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    a_d         = a_q;
    b_d         = b_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mul_d       = mul_a * mul_b;
    h_d         = h_q;
    pos_d       = pos_q;
    clr_d       = clr_q;
    probes_d    = probes_q;
    found_d     = found_q;
    next_id_d   = next_id_q;
    x_d         = x_q;
    clauses_d   = clauses_q;
    st_d        = st_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    tab_we      = 1'b0;
    tab_re      = 1'b0;
    tab_waddr   = pos_q;
    tab_wdata   = '{valid: 1'b1, kind: mode_q, lo: lo_q, hi: hi_q, id: x_q};

    unique case (state_q)
      S_CLEAR: begin
        tab_we    = 1'b1;
        tab_waddr = clr_q;
        tab_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == Aw'(TableDepth - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          if (f_single) begin
            res_d       = '{gate_id: f_id, has_clause: 1'b0, lit_first: '0,
                            lit_second: '0, lit_third: '0, clause_total: clauses_q,
                            status: tge_pkg::StatusOk, last: 1'b1};
            res_valid_d = 1'b1;
          end else begin
            mode_d = f_mode;
            a_d    = f_a;
            b_d    = f_b;
            // all kinds but IMPLIES key on (smaller, larger) by signed order
            if (f_mode != tge_pkg::KindImplies && $signed(f_a) > $signed(f_b)) begin
              lo_d = f_b; hi_d = f_a;
            end else begin
              lo_d = f_a; hi_d = f_b;
            end
            state_d = S_HASHA;
          end
        end
      end
      S_HASHA: state_d = S_HASHB;
      S_HASHB: begin
        h_d     = mul_q ^ ((32'(mode_q) + 32'd1) * tge_pkg::HashMulKind);
        state_d = S_HASHC;
      end
      S_HASHC: state_d = S_HASHD;
      S_HASHD: begin
        pos_d    = fin[Aw-1:0];
        probes_d = '0;
        state_d  = S_READ;
      end
      S_READ: begin
        tab_re  = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (!tab_rdata.valid) begin
          found_d = 1'b1;
          state_d = S_ALLOC;
        end else if (tab_rdata.kind == mode_q && tab_rdata.lo == lo_q &&
                     tab_rdata.hi == hi_q) begin
          res_d       = '{gate_id: {1'b0, tab_rdata.id}, has_clause: 1'b0,
                          lit_first: '0, lit_second: '0, lit_third: '0,
                          clause_total: clauses_q, status: tge_pkg::StatusOk,
                          last: 1'b1};
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else if (probes_q == (Aw+1)'(TableDepth - 1)) begin
          found_d = 1'b0;
          state_d = S_ALLOC;
        end else begin
          pos_d    = pos_q + 1'b1;
          probes_d = probes_q + 1'b1;
          state_d  = S_READ;
        end
      end
      S_ALLOC: begin
        if (next_id_q == '0 || next_id_q == tge_pkg::IdMax) begin
          res_d       = '{gate_id: '0, has_clause: 1'b0, lit_first: '0,
                          lit_second: '0, lit_third: '0, clause_total: clauses_q,
                          status: tge_pkg::StatusNoIds, last: 1'b1};
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          x_d       = next_id_q;
          next_id_d = next_id_q + 1'b1;
          tab_we    = found_q;
          tab_wdata = '{valid: 1'b1, kind: mode_q, lo: lo_q, hi: hi_q, id: next_id_q};
          st_d      = found_q ? tge_pkg::StatusOk : tge_pkg::StatusFull;
          cnt_d     = '0;
          state_d   = S_EMIT;
        end
      end
      S_EMIT: begin
        clauses_d   = clauses_q + 32'd1;
        res_d       = '{gate_id: xl, has_clause: 1'b1, lit_first: c1, lit_second: c2,
                        lit_third: c3, clause_total: clauses_q + 32'd1, status: st_q,
                        last: (cnt_q == n_last)};
        res_valid_d = 1'b1;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == n_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_we_i) begin
      next_id_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      next_id_q   <= 31'd1;
      clauses_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      next_id_q   <= next_id_d;
      clauses_q   <= clauses_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    a_q      <= a_d;
    b_q      <= b_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mul_q    <= mul_d;
    h_q      <= h_d;
    pos_q    <= pos_d;
    probes_q <= probes_d;
    found_q  <= found_d;
    x_q      <= x_d;
    st_q     <= st_d;
    cnt_q    <= cnt_d;
    res_q    <= res_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
